@@ sv/tss_pkg.sv @@
`default_nettype none
package tss_pkg;

  localparam int DutyW = 16;
  localparam int VoltW = 14;
  localparam int AngW  = 13;
  localparam int OffW  = 14;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 16;

  localparam logic [DutyW-1:0] DutyFloor = 16'd3276;

  typedef enum logic [2:0] {
    MODE_NONE    = 3'd0,
    MODE_DUTY    = 3'd1,
    MODE_HV      = 3'd2,
    MODE_LV      = 3'd3,
    MODE_BACKOFF = 3'd4
  } mode_t;

  localparam logic [CfgIdxW-1:0] REG_DUTY_THR  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_HV_THR    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_LV_THR    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_DUTY_ANG  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_HV_ANG    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_LV_ANG    = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_DUTY_STEP = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_VR_STEP   = 3'd7;

  typedef struct packed {
    logic [DutyW-1:0] duty_threshold;
    logic [VoltW-1:0] high_voltage_threshold;
    logic [VoltW-1:0] low_voltage_threshold;
    logic [AngW-1:0]  duty_angle;
    logic [AngW-1:0]  high_voltage_angle;
    logic [AngW-1:0]  low_voltage_angle;
    logic [AngW-1:0]  duty_step;
    logic [AngW-1:0]  voltage_and_return_step;
  } cfg_t;

  typedef struct packed {
    logic [DutyW-1:0] abs_duty;
    logic             forward;
    logic [VoltW-1:0] supply_voltage;
  } item_t;

  typedef struct packed {
    logic signed [OffW-1:0] tilt_offset;
    mode_t                  tilt_mode;
  } result_t;

endpackage
`default_nettype wire

@@ sv/tss_cfg_regs.sv @@
`default_nettype none
module tss_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          wr_en,
  input  wire logic [tss_pkg::CfgIdxW-1:0]   wr_index,
  input  wire logic [tss_pkg::CfgDataW-1:0]  wr_data,
  output tss_pkg::cfg_t                      cfg
);
  import tss_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.duty_threshold          <= 16'd55706;
      cfg.high_voltage_threshold  <= 14'd6000;
      cfg.low_voltage_threshold   <= 14'd4000;
      cfg.duty_angle              <= 13'd768;
      cfg.high_voltage_angle      <= 13'd768;
      cfg.low_voltage_angle       <= 13'd768;
      cfg.duty_step               <= 13'd3;
      cfg.voltage_and_return_step <= 13'd3;
    end else if (wr_en) begin
      case (wr_index)
        REG_DUTY_THR:  cfg.duty_threshold          <= wr_data[DutyW-1:0];
        REG_HV_THR:    cfg.high_voltage_threshold  <= wr_data[VoltW-1:0];
        REG_LV_THR:    cfg.low_voltage_threshold   <= wr_data[VoltW-1:0];
        REG_DUTY_ANG:  cfg.duty_angle              <= wr_data[AngW-1:0];
        REG_HV_ANG:    cfg.high_voltage_angle      <= wr_data[AngW-1:0];
        REG_LV_ANG:    cfg.low_voltage_angle       <= wr_data[AngW-1:0];
        REG_DUTY_STEP: cfg.duty_step               <= wr_data[AngW-1:0];
        REG_VR_STEP:   cfg.voltage_and_return_step <= wr_data[AngW-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ sv/tss_in_reg.sv @@
`default_nettype none
module tss_in_reg (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire tss_pkg::item_t in_item,
  input  wire logic  take,
  output logic       held_valid,
  output tss_pkg::item_t held_item
);
  import tss_pkg::*;

  logic load;

  assign in_stall = held_valid && !take;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_item <= in_item;
    end
  end

endmodule
`default_nettype wire

@@ sv/tss_engine.sv @@
`default_nettype none
module tss_engine (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      fire,
  input  wire tss_pkg::item_t item,
  input  wire tss_pkg::cfg_t  cfg,
  output tss_pkg::result_t result
);
  import tss_pkg::*;

  mode_t                  mode, mode_next, mode_hit;
  logic signed [OffW-1:0] target_angle, target_angle_next;
  logic signed [OffW-1:0] slewed_angle, slewed_angle_next;
  logic                   over_floor, hit_duty, hit_hv, hit_lv, hit;
  logic [AngW-1:0]        mag, step;
  logic signed [OffW-1:0] mag_s, step_s, target_sel;
  logic signed [OffW:0]   diff;
  logic [OffW:0]          abs_diff;
  logic                   done;

  always_comb begin
    over_floor = item.abs_duty > DutyFloor;
    hit_duty   = item.abs_duty > cfg.duty_threshold;
    hit_hv     = over_floor && (item.supply_voltage > cfg.high_voltage_threshold);
    hit_lv     = over_floor && (item.supply_voltage < cfg.low_voltage_threshold);
    hit        = hit_duty || hit_hv || hit_lv;

    if (hit_duty) begin
      mag      = cfg.duty_angle;
      mode_hit = MODE_DUTY;
    end else if (hit_hv) begin
      mag      = cfg.high_voltage_angle;
      mode_hit = MODE_HV;
    end else if (hit_lv) begin
      mag      = cfg.low_voltage_angle;
      mode_hit = MODE_LV;
    end else begin
      mag      = '0;
      mode_hit = mode;
    end
    mag_s      = $signed({1'b0, mag});
    target_sel = hit ? (item.forward ? mag_s : -mag_s) : target_angle;

    case (mode_hit)
      MODE_DUTY:                         step = cfg.duty_step;
      MODE_HV, MODE_LV, MODE_BACKOFF:    step = cfg.voltage_and_return_step;
      default:                           step = '0;
    endcase
    step_s = $signed({1'b0, step});

    diff     = {target_sel[OffW-1], target_sel} - {slewed_angle[OffW-1], slewed_angle};
    abs_diff = diff[OffW] ? unsigned'(-diff) : unsigned'(diff);
    done     = abs_diff <= {2'b00, step};
  end

  always_comb begin
    mode_next          = mode_hit;
    target_angle_next  = target_sel;
    slewed_angle_next  = slewed_angle;
    result.tilt_offset = '0;
    if (mode_hit != MODE_NONE) begin
      if (done) begin
        slewed_angle_next = target_sel;
        if (mode_hit == MODE_BACKOFF) begin
          mode_next = MODE_NONE;
        end else begin
          mode_next         = MODE_BACKOFF;
          target_angle_next = '0;
        end
      end else begin
        slewed_angle_next  = diff[OffW] ? slewed_angle - step_s : slewed_angle + step_s;
        result.tilt_offset = slewed_angle_next;
      end
    end
    result.tilt_mode = mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_NONE;
      target_angle <= '0;
      slewed_angle <= '0;
    end else if (fire) begin
      mode         <= mode_next;
      target_angle <= target_angle_next;
      slewed_angle <= slewed_angle_next;
    end
  end

endmodule
`default_nettype wire

@@ sv/tss_out_reg.sv @@
`default_nettype none
module tss_out_reg (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load,
  input  wire tss_pkg::result_t result,
  output logic             room,
  output logic             out_valid,
  input  wire logic        out_stall,
  output tss_pkg::result_t out_result
);
  import tss_pkg::*;

  assign room = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (room) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && room) begin
      out_result <= result;
    end
  end

endmodule
`default_nettype wire

@@ sv/tiltback_setpoint_sequencer.sv @@
// channel   direction  handshake           payload
// in        input      in_valid/in_stall   abs_duty, forward, supply_voltage
// out       output     out_valid/out_stall tilt_offset, tilt_mode
// cfg       input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// a request is taken into the input register, worked there by the engine and
// written to the output register with the mode state once it has room; one
// request per cycle sustained while out_stall is low; the output register holds
// while out_stall is high and in_stall rises once the input register also fills
// rst is synchronous and clears mode, angles and both valid flags
// cfg_ready is always high
`default_nettype none
module tiltback_setpoint_sequencer (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [tss_pkg::DutyW-1:0]         abs_duty,
  input  wire logic                              forward,
  input  wire logic [tss_pkg::VoltW-1:0]         supply_voltage,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [tss_pkg::OffW-1:0]        tilt_offset,
  output logic [2:0]                             tilt_mode,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [tss_pkg::CfgIdxW-1:0]       cfg_index,
  input  wire logic [tss_pkg::CfgDataW-1:0]      cfg_data
);
  import tss_pkg::*;

  cfg_t    cfg;
  item_t   in_item, held_item;
  result_t result, out_result;
  logic    held_valid, room, fire;

  assign cfg_ready = 1'b1;
  assign in_item   = '{abs_duty: abs_duty, forward: forward, supply_voltage: supply_voltage};
  assign fire      = held_valid && room;

  tss_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  tss_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .take       (fire),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  tss_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (held_item),
    .cfg    (cfg),
    .result (result)
  );

  tss_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (held_valid),
    .result     (result),
    .room       (room),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

  assign tilt_offset = out_result.tilt_offset;
  assign tilt_mode   = out_result.tilt_mode;

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (tilt_mode == MODE_NONE) |-> tilt_offset == '0)
    else $error("nonzero offset with mode none");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output stage free");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule
`default_nettype wire

@@ tb/tiltback_setpoint_sequencer_test.sv @@
`timescale 1ns / 1ps
module tiltback_setpoint_sequencer_test;
  import tss_pkg::*;

  typedef enum int {TK_CALM, TK_DUTY, TK_HV, TK_LV, TK_NOISE} tick_kind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [DutyW-1:0] abs_duty = '0;
  logic forward = 1'b0;
  logic [VoltW-1:0] supply_voltage = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [OffW-1:0] tilt_offset;
  logic [2:0] tilt_mode;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // mirror of the sequencer registers and state
  cfg_t model_cfg = '{duty_threshold: 16'd55706, high_voltage_threshold: 14'd6000,
                      low_voltage_threshold: 14'd4000, duty_angle: 13'd768,
                      high_voltage_angle: 13'd768, low_voltage_angle: 13'd768,
                      duty_step: 13'd3, voltage_and_return_step: 13'd3};
  mode_t cur_mode = MODE_NONE;
  int goal_ang = 0;
  int trail_ang = 0;

  result_t tilt_expected[$];
  int ticks_sent = 0;
  int results_checked = 0;
  int cfg_writes = 0;
  int errs = 0;
  int mode_hits[5] = '{0, 0, 0, 0, 0};
  bit quiet = 1'b0;

  tiltback_setpoint_sequencer u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .abs_duty(abs_duty), .forward(forward), .supply_voltage(supply_voltage),
    .out_valid(out_valid), .out_stall(out_stall),
    .tilt_offset(tilt_offset), .tilt_mode(tilt_mode),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic result_t advance_tilt(item_t t);
    result_t r;
    int mag;
    int stp;
    int gap;
    bit hit_done;
    mag = -1;
    hit_done = 1'b0;
    r.tilt_offset = '0;
    if (t.abs_duty > model_cfg.duty_threshold) begin
      mag = int'(model_cfg.duty_angle);
      cur_mode = MODE_DUTY;
    end else if (t.abs_duty > DutyFloor &&
                 t.supply_voltage > model_cfg.high_voltage_threshold) begin
      mag = int'(model_cfg.high_voltage_angle);
      cur_mode = MODE_HV;
    end else if (t.abs_duty > DutyFloor &&
                 t.supply_voltage < model_cfg.low_voltage_threshold) begin
      mag = int'(model_cfg.low_voltage_angle);
      cur_mode = MODE_LV;
    end
    if (mag >= 0) goal_ang = t.forward ? mag : -mag;
    if (cur_mode != MODE_NONE) begin
      stp = (cur_mode == MODE_DUTY) ? int'(model_cfg.duty_step)
                                    : int'(model_cfg.voltage_and_return_step);
      gap = goal_ang - trail_ang;
      if ((gap < 0 ? -gap : gap) <= stp) begin
        trail_ang = goal_ang;
        hit_done = 1'b1;
      end else begin
        trail_ang = (gap > 0) ? trail_ang + stp : trail_ang - stp;
      end
      if (hit_done && cur_mode == MODE_BACKOFF) begin
        cur_mode = MODE_NONE;
      end else if (hit_done) begin
        cur_mode = MODE_BACKOFF;
        goal_ang = 0;
      end else begin
        r.tilt_offset = trail_ang[OffW-1:0];
      end
    end
    r.tilt_mode = cur_mode;
    return r;
  endfunction

  function automatic item_t make_tick(tick_kind_t kind, bit dir);
    item_t t;
    int unsigned thr_d;
    int unsigned hv;
    int unsigned lv;
    int unsigned flo;
    int unsigned lo_d;
    thr_d = 32'(model_cfg.duty_threshold);
    hv = 32'(model_cfg.high_voltage_threshold);
    lv = 32'(model_cfg.low_voltage_threshold);
    flo = 32'(DutyFloor);
    t.abs_duty = 16'($urandom);
    t.supply_voltage = 14'($urandom);
    t.forward = dir;
    case (kind)
      TK_DUTY: begin
        if (thr_d < 65535) t.abs_duty = 16'($urandom_range(65535, thr_d + 1));
      end
      TK_HV: begin
        if (thr_d > flo && hv < 16383) begin
          t.abs_duty = 16'($urandom_range(thr_d, flo + 1));
          t.supply_voltage = 14'($urandom_range(16383, hv + 1));
        end
      end
      TK_LV: begin
        if (thr_d > flo && lv > 0) begin
          t.abs_duty = 16'($urandom_range(thr_d, flo + 1));
          t.supply_voltage = 14'($urandom_range(lv - 1, 0));
        end
      end
      TK_CALM: begin
        if (lv <= hv && thr_d > flo && $urandom_range(0, 1) == 0) begin
          t.abs_duty = 16'($urandom_range(thr_d, flo + 1));
          t.supply_voltage = 14'($urandom_range(hv, lv));
        end else begin
          lo_d = (thr_d < flo) ? thr_d : flo;
          t.abs_duty = 16'($urandom_range(lo_d, 0));
        end
      end
      default: ;
    endcase
    return t;
  endfunction

  task automatic send_tick(item_t t);
    in_valid <= 1'b1;
    abs_duty <= t.abs_duty;
    forward <= t.forward;
    supply_voltage <= t.supply_voltage;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tilt_expected.push_back(advance_tilt(t));
    ticks_sent++;
    if (!quiet && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // hold off requests until every expected result is back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tilt_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_DUTY_THR:  model_cfg.duty_threshold = data;
      REG_HV_THR:    model_cfg.high_voltage_threshold = data[VoltW-1:0];
      REG_LV_THR:    model_cfg.low_voltage_threshold = data[VoltW-1:0];
      REG_DUTY_ANG:  model_cfg.duty_angle = data[AngW-1:0];
      REG_HV_ANG:    model_cfg.high_voltage_angle = data[AngW-1:0];
      REG_LV_ANG:    model_cfg.low_voltage_angle = data[AngW-1:0];
      REG_DUTY_STEP: model_cfg.duty_step = data[AngW-1:0];
      REG_VR_STEP:   model_cfg.voltage_and_return_step = data[AngW-1:0];
      default: ;
    endcase
    cfg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_regs(logic [15:0] d_thr, logic [15:0] hv_thr, logic [15:0] lv_thr,
                           logic [15:0] d_ang, logic [15:0] hv_ang, logic [15:0] lv_ang,
                           logic [15:0] d_stp, logic [15:0] vr_stp);
    write_reg(REG_DUTY_THR, d_thr);
    write_reg(REG_HV_THR, hv_thr);
    write_reg(REG_LV_THR, lv_thr);
    write_reg(REG_DUTY_ANG, d_ang);
    write_reg(REG_HV_ANG, hv_ang);
    write_reg(REG_LV_ANG, lv_ang);
    write_reg(REG_DUTY_STEP, d_stp);
    write_reg(REG_VR_STEP, vr_stp);
  endtask

  // calm ticks until the tilt has returned to none or limit ticks are sent
  task automatic coast(int limit);
    int n;
    n = 0;
    while (cur_mode != MODE_NONE && n < limit) begin
      send_tick(make_tick(TK_CALM, 1'($urandom)));
      n++;
    end
  endtask

  task automatic run_episode();
    tick_kind_t kind;
    bit dir;
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 10)) send_tick(make_tick(TK_NOISE, 1'($urandom)));
    end else begin
      kind = tick_kind_t'($urandom_range(TK_DUTY, TK_LV));
      dir = 1'($urandom);
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 7) == 0) dir = ~dir;
        send_tick(make_tick(kind, dir));
      end
      coast(($urandom_range(0, 9) == 0) ? int'($urandom_range(1, 8)) : 120);
    end
  endtask

  task automatic test_power_on_defaults();
    send_tick({16'd0, 1'b0, 14'd0});
    send_tick({16'd3276, 1'b1, 14'h3FFF});
    send_tick({16'd3277, 1'b1, 14'd6000});
    send_tick({16'd3277, 1'b0, 14'd4000});
    send_tick({16'd55706, 1'b0, 14'd5000});
    send_tick({16'd55707, 1'b1, 14'd5000});
    send_tick({16'hFFFF, 1'b0, 14'h3FFF});
  endtask

  task automatic test_each_mode();
    settle();
    load_regs(16'd55706, 16'd6000, 16'd4000, 16'd10, 16'd6, 16'd5, 16'd4, 16'd4);
    send_tick({16'hFFFF, 1'b1, 14'd5000});
    coast(10);
    send_tick({16'd10000, 1'b0, 14'h3FFF});
    coast(10);
    send_tick({16'd3277, 1'b1, 14'd0});
    coast(10);
    // duty outranks high voltage, then retarget to high voltage mid slew
    send_tick({16'hFFFF, 1'b1, 14'h3FFF});
    send_tick({16'd10000, 1'b0, 14'h3FFF});
    coast(10);
  endtask

  task automatic test_register_extremes();
    settle();
    load_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    repeat (30) send_tick(make_tick(TK_NOISE, 1'($urandom)));
    settle();
    // upper bits of the write data fall outside the narrower registers
    load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (30) send_tick(make_tick(TK_NOISE, 1'($urandom)));
    settle();
    load_regs(16'hFFFF, 16'd0, 16'd0, 16'd8191, 16'd8191, 16'd8191, 16'd0, 16'd8191);
    repeat (30) send_tick(make_tick(TK_NOISE, 1'($urandom)));
    settle();
    load_regs(16'd0, 16'd16383, 16'd0, 16'd8191, 16'd0, 16'd0, 16'd8191, 16'd1);
    repeat (10) send_tick(make_tick(TK_DUTY, 1'($urandom)));
    repeat (20) send_tick(make_tick(TK_NOISE, 1'($urandom)));
  endtask

  task automatic test_random_episodes();
    int stop_at;
    int unsigned hv;
    int unsigned lv;
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      hv = $urandom_range(3000, 15000);
      lv = ($urandom_range(0, 5) == 0) ? $urandom_range(hv, 16383) : $urandom_range(200, hv);
      load_regs(16'($urandom_range(8000, 60000)),
                16'(($urandom & 16'hC000) | hv),
                16'(($urandom & 16'hC000) | lv),
                16'(($urandom & 16'hE000) | $urandom_range(0, 300)),
                16'(($urandom & 16'hE000) | $urandom_range(0, 300)),
                16'(($urandom & 16'hE000) | $urandom_range(0, 300)),
                16'(($urandom & 16'hE000) |
                    (($urandom_range(0, 9) == 0) ? 0 : $urandom_range(8, 64))),
                16'(($urandom & 16'hE000) | $urandom_range(8, 64)));
      if (ph == 7) quiet = 1'b1;
      stop_at = ticks_sent + 200;
      while (ticks_sent < stop_at) run_episode();
    end
  endtask

  always begin
    @(posedge clk);
    if (!quiet && !rst && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 14)) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (tilt_expected.size() == 0) begin
        $error("unexpected result: tilt_offset %0d tilt_mode %0d", tilt_offset, tilt_mode);
        errs++;
      end else begin
        want = tilt_expected.pop_front();
        if (tilt_offset !== want.tilt_offset) begin
          $error("tilt_offset: expected %0d, got %0d", want.tilt_offset, tilt_offset);
          errs++;
        end
        if (tilt_mode !== want.tilt_mode) begin
          $error("tilt_mode: expected %0d, got %0d", want.tilt_mode, tilt_mode);
          errs++;
        end
        if (want.tilt_mode <= MODE_BACKOFF) mode_hits[want.tilt_mode]++;
        results_checked++;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_power_on_defaults();
    test_each_mode();
    test_register_extremes();
    test_random_episodes();
    settle();
    repeat (10) @(posedge clk);
    $display("tb: %0d ticks, %0d results checked, %0d register writes",
             ticks_sent, results_checked, cfg_writes);
    $display("tb: results per mode none %0d duty %0d hv %0d lv %0d backoff %0d",
             mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3], mode_hits[4]);
    if (errs == 0 && tilt_expected.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/tss_pkg.sv
sv/tss_cfg_regs.sv
sv/tss_in_reg.sv
sv/tss_engine.sv
sv/tss_out_reg.sv
sv/tiltback_setpoint_sequencer.sv
tb/tiltback_setpoint_sequencer_test.sv
